>>> src/scs_pkg.sv
package scs_pkg;

    // Copy alignment in bytes (a power of two) and derived masks
    localparam int unsigned COPY_ALIGN  = 4;
    localparam int unsigned ALIGN_BITS  = $clog2(COPY_ALIGN);
    localparam logic [27:0] ALIGN_MASK  = 28'(COPY_ALIGN - 1);

    // Field widths
    localparam int unsigned UNITS_W        = 25;
    localparam int unsigned CHUNK_BYTES_W  = 27;
    localparam int unsigned SIZE_W         = 32;
    localparam int unsigned INDEX_W        = 32;
    localparam int unsigned STAGING_OFF_W  = 26;
    localparam int unsigned PIECE_BYTES_W  = 27;

    // Chunk size register: reset value and legal span
    localparam logic [UNITS_W-1:0] UNITS_RESET = 25'd1024;
    localparam logic [UNITS_W-1:0] UNITS_MAX   = 25'd16777216;
    localparam logic [UNITS_W-1:0] UNITS_MIN   = 25'd1;

    // Last chunk index that may never be opened
    localparam logic [INDEX_W-1:0] CHUNK_INDEX_LIMIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_ZERO_SIZE   = 2'd1,
        ERR_CHUNK_LIMIT = 2'd2
    } err_code_t;

    // One upload transaction as seen by the piece engine
    typedef struct packed {
        logic [SIZE_W-1:0] upload_size;
        logic              final_upload;
    } upload_item_t;

    // One copy piece
    typedef struct packed {
        logic [INDEX_W-1:0]       piece_upload_index;
        logic [INDEX_W-1:0]       piece_chunk_index;
        logic [STAGING_OFF_W-1:0] staging_offset;
        logic [SIZE_W-1:0]        target_offset;
        logic [PIECE_BYTES_W-1:0] piece_bytes;
        logic                     upload_done;
        logic                     chunk_done;
        logic                     batch_done;
        err_code_t                error_code;
    } piece_t;

    // Round a byte count up to the copy alignment
    function automatic logic [27:0] round_up_align(input logic [27:0] v);
        logic [27:0] sum;
        sum = v + ALIGN_MASK;
        return sum & ~ALIGN_MASK;
    endfunction

endpackage

>>> src/scs_input_stage.sv
module scs_input_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upload_valid,
    output logic                  upload_stall,
    input  scs_pkg::upload_item_t item_in,
    input  logic                  take,
    output logic                  item_valid,
    output scs_pkg::upload_item_t item_out
);

    logic                  valid_reg;
    logic                  valid_next;
    scs_pkg::upload_item_t item_reg;
    logic                  load;

    // Load a new transaction when the register is empty or is drained this cycle
    assign load         = !valid_reg || take;
    assign upload_stall = !load;
    assign valid_next   = load ? upload_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge clk)
    begin
        if (load && upload_valid)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

>>> src/scs_piece_engine.sv
module scs_piece_engine (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [scs_pkg::CHUNK_BYTES_W-1:0]         chunk_bytes,
    input  scs_pkg::upload_item_t                     item,
    input  logic                                      fire,
    output scs_pkg::piece_t                           piece
);

    logic [scs_pkg::CHUNK_BYTES_W-1:0] chunk_fill_reg,      chunk_fill_next;
    logic [scs_pkg::SIZE_W-1:0]        upload_progress_reg, upload_progress_next;
    logic [scs_pkg::INDEX_W-1:0]       upload_counter_reg,  upload_counter_next;
    logic [scs_pkg::INDEX_W-1:0]       chunk_counter_reg,   chunk_counter_next;

    logic [27:0]                       fill_up;
    logic [27:0]                       src_wide;
    logic [scs_pkg::CHUNK_BYTES_W-1:0] src;
    logic [scs_pkg::CHUNK_BYTES_W-1:0] avail;
    logic [scs_pkg::SIZE_W-1:0]        remaining;
    logic                              short_piece;
    logic [scs_pkg::CHUNK_BYTES_W-1:0] piece_len;
    logic [27:0]                       new_fill;
    logic                              up_done;
    logic                              b_done;
    logic                              ch_done;
    logic                              err_zero;
    logic                              err_limit;

    // Place the piece: aligned start, bounded by chunk space and bytes left
    always_comb
    begin
        fill_up     = scs_pkg::round_up_align({1'b0, chunk_fill_reg});
        src_wide    = (fill_up >= {1'b0, chunk_bytes}) ? {1'b0, chunk_bytes} : fill_up;
        src         = src_wide[scs_pkg::CHUNK_BYTES_W-1:0];
        avail       = chunk_bytes - src;
        remaining   = item.upload_size - upload_progress_reg;
        short_piece = {5'b0, avail} < remaining;
        if (short_piece)
        begin
            piece_len = avail & ~scs_pkg::ALIGN_MASK[scs_pkg::CHUNK_BYTES_W-1:0];
        end
        else
        begin
            piece_len = remaining[scs_pkg::CHUNK_BYTES_W-1:0];
        end
        new_fill  = {1'b0, src} + {1'b0, piece_len};
        up_done   = !short_piece;
        b_done    = up_done && item.final_upload;
        ch_done   = b_done ||
                    (scs_pkg::round_up_align(new_fill) >= {1'b0, chunk_bytes});
        err_zero  = item.upload_size <= upload_progress_reg;
        err_limit = (chunk_fill_reg == '0) &&
                    (chunk_counter_reg == scs_pkg::CHUNK_INDEX_LIMIT);
    end

    // Form the result; an error abandons the batch
    always_comb
    begin
        piece.piece_upload_index = upload_counter_reg;
        piece.piece_chunk_index  = chunk_counter_reg;
        if (err_zero || err_limit)
        begin
            piece.staging_offset = '0;
            piece.target_offset  = '0;
            piece.piece_bytes    = '0;
            piece.upload_done    = 1'b0;
            piece.chunk_done     = 1'b0;
            piece.batch_done     = 1'b1;
            piece.error_code     = err_zero ? scs_pkg::ERR_ZERO_SIZE
                                            : scs_pkg::ERR_CHUNK_LIMIT;
        end
        else
        begin
            piece.staging_offset = src[scs_pkg::STAGING_OFF_W-1:0];
            piece.target_offset  = upload_progress_reg;
            piece.piece_bytes    = piece_len;
            piece.upload_done    = up_done;
            piece.chunk_done     = ch_done;
            piece.batch_done     = b_done;
            piece.error_code     = scs_pkg::ERR_NONE;
        end
    end

    // Advance the running counters
    always_comb
    begin
        chunk_fill_next      = chunk_fill_reg;
        upload_progress_next = upload_progress_reg;
        upload_counter_next  = upload_counter_reg;
        chunk_counter_next   = chunk_counter_reg;
        if (fire)
        begin
            if (err_zero || err_limit || b_done)
            begin
                chunk_fill_next      = '0;
                upload_progress_next = '0;
                upload_counter_next  = '0;
                chunk_counter_next   = '0;
            end
            else
            begin
                if (up_done)
                begin
                    upload_progress_next = '0;
                    upload_counter_next  = upload_counter_reg + 32'd1;
                end
                else
                begin
                    upload_progress_next = upload_progress_reg + {5'b0, piece_len};
                end
                if (ch_done)
                begin
                    chunk_fill_next    = '0;
                    chunk_counter_next = chunk_counter_reg + 32'd1;
                end
                else
                begin
                    chunk_fill_next = new_fill[scs_pkg::CHUNK_BYTES_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_fill_reg      <= '0;
            upload_progress_reg <= '0;
            upload_counter_reg  <= '0;
            chunk_counter_reg   <= '0;
        end
        else
        begin
            chunk_fill_reg      <= chunk_fill_next;
            upload_progress_reg <= upload_progress_next;
            upload_counter_reg  <= upload_counter_next;
            chunk_counter_reg   <= chunk_counter_next;
        end
    end

endmodule

>>> src/staging_chunk_segmenter.sv
// Staging chunk segmenter: splits a batch of uploads into aligned copy pieces packed
// into staging chunks of chunk_size_units * 4 bytes. Present the current upload's
// size (with final_upload on the last upload) once per piece, repeating it until a
// piece comes back with upload_done. One piece leaves for every upload transaction,
// one per clock when neither side stalls, passing through one input register, then the
// piece engine whose running chunk and upload counters update when the piece moves
// on, then the result register. A zero size, a size at or below the bytes already
// placed, or an attempt to open chunk index 0xFFFFFFFF returns an error piece with
// batch_done set and restarts the batch. Write cfg_write_data only while no
// transaction is in flight; 0 reads as 1 unit and values above 2^24 as 2^24.
module staging_chunk_segmenter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [scs_pkg::UNITS_W-1:0]         cfg_write_data,
    input  logic                                upload_valid,
    output logic                                upload_stall,
    input  logic [scs_pkg::SIZE_W-1:0]          upload_size,
    input  logic                                final_upload,
    output logic                                piece_valid,
    input  logic                                piece_stall,
    output logic [scs_pkg::INDEX_W-1:0]         piece_upload_index,
    output logic [scs_pkg::INDEX_W-1:0]         piece_chunk_index,
    output logic [scs_pkg::STAGING_OFF_W-1:0]   staging_offset,
    output logic [scs_pkg::SIZE_W-1:0]          target_offset,
    output logic [scs_pkg::PIECE_BYTES_W-1:0]   piece_bytes,
    output logic                                upload_done,
    output logic                                chunk_done,
    output logic                                batch_done,
    output logic [1:0]                          error_code
);

    logic [scs_pkg::UNITS_W-1:0]       units_reg;
    logic [scs_pkg::UNITS_W-1:0]       units_eff;
    logic [scs_pkg::CHUNK_BYTES_W-1:0] chunk_bytes;
    scs_pkg::upload_item_t             item_in;
    scs_pkg::upload_item_t             item;
    logic                              item_valid;
    logic                              out_ready;
    logic                              fire;
    scs_pkg::piece_t                   piece;
    scs_pkg::piece_t                   piece_reg;
    logic                              piece_valid_reg;
    logic                              piece_valid_next;

    // Chunk size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg <= scs_pkg::UNITS_RESET;
        end
        else if (cfg_write_en)
        begin
            units_reg <= cfg_write_data;
        end
    end

    // Clamp the unit count and scale to bytes
    always_comb
    begin
        if (units_reg[scs_pkg::UNITS_W-1])
        begin
            units_eff = scs_pkg::UNITS_MAX;
        end
        else if (units_reg == '0)
        begin
            units_eff = scs_pkg::UNITS_MIN;
        end
        else
        begin
            units_eff = units_reg;
        end
        chunk_bytes = scs_pkg::CHUNK_BYTES_W'(units_eff) << scs_pkg::ALIGN_BITS;
    end

    assign item_in.upload_size  = upload_size;
    assign item_in.final_upload = final_upload;

    scs_input_stage u_input_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .upload_valid (upload_valid),
        .upload_stall (upload_stall),
        .item_in      (item_in),
        .take         (fire),
        .item_valid   (item_valid),
        .item_out     (item)
    );

    // Move a transaction into the result register when it is free or drains
    assign out_ready = !piece_valid_reg || !piece_stall;
    assign fire      = item_valid && out_ready;

    scs_piece_engine u_piece_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk_bytes (chunk_bytes),
        .item        (item),
        .fire        (fire),
        .piece       (piece)
    );

    assign piece_valid_next = out_ready ? item_valid : piece_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_valid_reg <= 1'b0;
        end
        else
        begin
            piece_valid_reg <= piece_valid_next;
        end
    end

    // Hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            piece_reg <= piece;
        end
    end

    assign piece_valid        = piece_valid_reg;
    assign piece_upload_index = piece_reg.piece_upload_index;
    assign piece_chunk_index  = piece_reg.piece_chunk_index;
    assign staging_offset     = piece_reg.staging_offset;
    assign target_offset      = piece_reg.target_offset;
    assign piece_bytes        = piece_reg.piece_bytes;
    assign upload_done        = piece_reg.upload_done;
    assign chunk_done         = piece_reg.chunk_done;
    assign batch_done         = piece_reg.batch_done;
    assign error_code         = piece_reg.error_code;

    // An error piece carries no bytes and ends the batch
    assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && (error_code != scs_pkg::ERR_NONE) |->
            batch_done && (piece_bytes == '0) && !upload_done && !chunk_done)
        else $error("error piece not reported as abandoned batch");

    // A clean batch end closes both the upload and the chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && batch_done && (error_code == scs_pkg::ERR_NONE) |->
            upload_done && chunk_done)
        else $error("batch end without upload and chunk close");

    // A piece never runs past the end of its chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && (error_code == scs_pkg::ERR_NONE) |->
            ({2'b0, staging_offset} + {1'b0, piece_bytes}) <= {1'b0, chunk_bytes})
        else $error("piece overruns staging chunk");

endmodule
